FILE: design/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants for the piecewise linear interpolator
// Request and result payloads, status and action codes, table sizing.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W    = 7;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int QUOT_W     = FRAC_W + 1;

    typedef enum logic {
        ACTION_LOAD  = 1'b0,
        ACTION_QUERY = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_FEW_POINTS   = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2,
        STATUS_NO_INTERVAL  = 2'd3
    } t_status;

    typedef struct packed {
        t_action                  action;
        logic [ADDR_W-1:0]        point_index;
        logic signed [DATA_W-1:0] point_coord;
        logic signed [DATA_W-1:0] point_value;
        logic signed [DATA_W-1:0] query_coord;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        t_status                  status;
    } t_result;

endpackage

FILE: design/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div: serial fraction divider
// Returns floor(dividend * 2^16 / divisor) for dividend <= divisor, one
// quotient bit per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module pli_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pli_pkg::DATA_W-1:0]   i_dividend,
    input  logic [pli_pkg::DATA_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [pli_pkg::QUOT_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(pli_pkg::QUOT_W + 1);

    logic [pli_pkg::DATA_W:0]   r_rem;
    logic [pli_pkg::DATA_W-1:0] r_div;
    logic [pli_pkg::QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_first;
    logic                       r_done;

    logic [pli_pkg::DATA_W:0]   trial;
    logic                       fits;

    // First step compares the dividend itself; later steps shift in a zero.
    assign trial = r_first ? r_rem : {r_rem[pli_pkg::DATA_W-1:0], 1'b0};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(pli_pkg::QUOT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= {1'b0, i_dividend};
            r_div   <= i_divisor;
            r_quot  <= '0;
            r_first <= 1'b1;
        end else if (r_cnt != '0) begin
            r_rem   <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quot  <= {r_quot[pli_pkg::QUOT_W-2:0], fits};
            r_first <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

FILE: design/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table with linear interpolation
// Loads breakpoints into a 64-entry table and answers queries by a linear
// search for the holding interval, a serial fraction divide and one multiply.
// ----------------------------------------------------------------------------
// A load is answered straight from idle, as is a query when fewer than two
// points are in use; other queries read and check the range, then scan the
// intervals in turn on the table read ports (a read, then a check for each),
// then divide and sum. One request at a time; busy is high outside idle.
// The result strobe is one cycle and cannot be stalled. Synchronous reset
// clears control and point_count; table contents are undefined until loaded.
module piecewise_linear_interpolator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pli_pkg::t_req                     i_req,
    input  logic                              i_cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]       i_cfg_data,
    output logic                              o_result_valid,
    output pli_pkg::t_result                  o_result
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_RANGE_RD  = 7'b0000010,
        ST_RANGE_CHK = 7'b0000100,
        ST_SCAN_RD   = 7'b0001000,
        ST_SCAN_CHK  = 7'b0010000,
        ST_DIV       = 7'b0100000,
        ST_FIN       = 7'b1000000
    } t_state;

    localparam int DW   = pli_pkg::DATA_W;
    localparam int AW   = pli_pkg::ADDR_W;
    localparam int PW   = pli_pkg::QUOT_W + 1 + DW + 1;

    t_state r_state, n_state;

    logic [pli_pkg::COUNT_W-1:0] r_count;
    logic [pli_pkg::COUNT_W-1:0] r_n, n_n;
    logic [AW-1:0]               r_ia, n_ia;
    logic [AW-1:0]               r_ib, n_ib;
    logic signed [DW-1:0]        r_x, n_x;

    logic [DW-1:0]               r_coord_mem [pli_pkg::MAX_POINTS];
    logic [DW-1:0]               r_value_mem [pli_pkg::MAX_POINTS];
    logic signed [DW-1:0]        r_rd_xa, r_rd_xb, r_rd_va, r_rd_vb;

    logic signed [DW-1:0]        r_v0, n_v0;
    logic signed [DW:0]          r_dv, n_dv;
    logic signed [PW-1:0]        r_prod;

    logic                        r_out_valid, n_out_valid;
    pli_pkg::t_result            r_out, n_out;

    logic                        accept, load_we;
    logic                        div_start, div_done;
    logic [pli_pkg::QUOT_W-1:0]  div_quot;
    logic [pli_pkg::COUNT_W-1:0] eff_count;
    logic signed [DW:0]          dx_full, w_full;
    logic signed [PW-1:0]        rounded;

    assign accept    = start && (r_state == ST_IDLE);
    assign load_we   = accept && (i_req.action == pli_pkg::ACTION_LOAD);
    assign eff_count = (r_count > pli_pkg::COUNT_W'(pli_pkg::MAX_POINTS))
                     ? pli_pkg::COUNT_W'(pli_pkg::MAX_POINTS) : r_count;
    assign dx_full   = {r_x[DW-1], r_x} - {r_rd_xa[DW-1], r_rd_xa};
    assign w_full    = {r_rd_xb[DW-1], r_rd_xb} - {r_rd_xa[DW-1], r_rd_xa};
    assign rounded   = (r_prod + PW'(signed'(1 << (pli_pkg::FRAC_W - 1)))) >>> pli_pkg::FRAC_W;

    // Operands are taken straight from the scan compare in the start cycle.
    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dx_full[DW-1:0]),
        .i_divisor  (w_full[DW-1:0]),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Table memories: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_coord_mem[i_req.point_index] <= i_req.point_coord;
            r_value_mem[i_req.point_index] <= i_req.point_value;
        end
        r_rd_xa <= r_coord_mem[r_ia];
        r_rd_xb <= r_coord_mem[r_ib];
        r_rd_va <= r_value_mem[r_ia];
        r_rd_vb <= r_value_mem[r_ib];
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_x         = r_x;
        n_v0        = r_v0;
        n_dv        = r_dv;
        n_out_valid = 1'b0;
        n_out       = r_out;
        div_start   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out.result_value = '0;
                    n_out.status       = pli_pkg::STATUS_OK;
                    n_x                = i_req.query_coord;
                    n_n                = eff_count;
                    if (i_req.action == pli_pkg::ACTION_LOAD) begin
                        n_out_valid = 1'b1;
                    end else if (eff_count < pli_pkg::COUNT_W'(2)) begin
                        n_out.status = pli_pkg::STATUS_FEW_POINTS;
                        n_out_valid  = 1'b1;
                    end else begin
                        n_ia    = '0;
                        n_ib    = AW'(eff_count - 1'b1);
                        n_state = ST_RANGE_RD;
                    end
                end
            end
            ST_RANGE_RD: begin
                n_state = ST_RANGE_CHK;
            end
            ST_RANGE_CHK: begin
                if (r_x < r_rd_xa || r_x > r_rd_xb) begin
                    n_out.result_value = '0;
                    n_out.status       = pli_pkg::STATUS_OUT_OF_RANGE;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    n_ia    = '0;
                    n_ib    = AW'(1);
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (r_x >= r_rd_xa && r_x <= r_rd_xb) begin
                    n_v0 = r_rd_va;
                    n_dv = {r_rd_vb[DW-1], r_rd_vb} - {r_rd_va[DW-1], r_rd_va};
                    if (w_full == '0) begin
                        // Zero-width interval: return the left value.
                        n_out.result_value = r_rd_va;
                        n_out.status       = pli_pkg::STATUS_OK;
                        n_out_valid        = 1'b1;
                        n_state            = ST_IDLE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end else if ({1'b0, r_ib} == r_n - 1'b1) begin
                    n_out.result_value = '0;
                    n_out.status       = pli_pkg::STATUS_NO_INTERVAL;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    n_ia    = r_ib;
                    n_ib    = r_ib + 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_out.result_value = r_v0 + rounded[DW-1:0];
                n_out.status       = pli_pkg::STATUS_OK;
                n_out_valid        = 1'b1;
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_ia  <= n_ia;
        r_ib  <= n_ib;
        r_x   <= n_x;
        r_v0  <= n_v0;
        r_dv  <= n_dv;
        r_out <= n_out;
        // Weight times value difference; quotient is held once the divide ends.
        if (r_state == ST_DIV && div_done) begin
            r_prod <= PW'(signed'({1'b0, div_quot})) * PW'(r_dv);
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

FILE: tb/interp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interp_result_checker: result predictor and comparator for the interpolator
// Tracks the breakpoint table and point count from accepted requests and
// register writes, predicts each result, and compares it against the result
// strobe in order.
// ----------------------------------------------------------------------------
module interp_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  pli_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic                          i_result_valid,
    input  pli_pkg::t_result              i_result,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    import pli_pkg::*;

    logic [COUNT_W-1:0]       point_count;
    logic signed [DATA_W-1:0] coord_tab [MAX_POINTS];
    logic signed [DATA_W-1:0] value_tab [MAX_POINTS];
    t_result                  expected_results [$];
    t_result                  want;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic t_result interpolate_at(input logic signed [DATA_W-1:0] x);
        t_result res;
        int      n;
        bit      hit;
        longint  x0, x1, v0, v1, frac, acc;
        res.result_value = '0;
        res.status       = STATUS_OK;
        hit              = 1'b0;
        n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
        if (n < 2) begin
            res.status = STATUS_FEW_POINTS;
        end else if (x < coord_tab[0] || x > coord_tab[n-1]) begin
            res.status = STATUS_OUT_OF_RANGE;
        end else begin
            // first interval from the bottom that holds x wins
            for (int i = 0; i < n - 1; i++) begin
                x0 = coord_tab[i];
                x1 = coord_tab[i+1];
                if (!hit && x >= x0 && x <= x1) begin
                    hit = 1'b1;
                    v0  = value_tab[i];
                    v1  = value_tab[i+1];
                    if (x1 == x0) begin
                        acc = v0;
                    end else begin
                        frac = ((x - x0) <<< FRAC_W) / (x1 - x0);
                        // round half up, then floor by arithmetic shift
                        acc  = ((65536 - frac) * v0 + frac * v1 + 32768) >>> FRAC_W;
                    end
                    res.result_value = acc[DATA_W-1:0];
                end
            end
            if (!hit) res.status = STATUS_NO_INTERVAL;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_count = '0;
            expected_results.delete();
        end else begin
            // retire before predicting: a result never belongs to this edge's request
            if (i_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result_value %0d status %0d",
                           i_result.result_value, i_result.status);
                    o_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, actual %0d",
                               want.result_value, i_result.result_value);
                        o_mismatches++;
                    end
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_result.status);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_we) point_count = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_req.action == ACTION_LOAD) begin
                    coord_tab[i_req.point_index] = i_req.point_coord;
                    value_tab[i_req.point_index] = i_req.point_value;
                    want.result_value = '0;
                    want.status       = STATUS_OK;
                end else begin
                    want = interpolate_at(i_req.query_coord);
                end
                expected_results.push_back(want);
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

FILE: tb/piecewise_linear_interpolator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_test: top level of the interpolator testbench
// Drives breakpoint loads, queries and point count writes with random gaps,
// and reports the verdict from the result checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_test;
    import pli_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int ITEM_TARGET  = 550;
    localparam int DRAIN_CYCLES = 300;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_req               i_req;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_data;
    logic               o_result_valid;
    t_result            o_result;

    int mismatches;
    int outstanding;
    int items_sent;
    int stall_cycles;
    int active_points;
    bit no_gaps;

    // stimulus-side copy of the coordinates, used to aim queries
    logic signed [DATA_W-1:0] table_coord [MAX_POINTS];

    piecewise_linear_interpolator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    interp_result_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // hold start until the request is taken; leave it high for a back-to-back request
    task automatic send(input t_req r);
        int gap;
        i_req = r;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        gap = gap_cycles();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic load_point(input int slot, input logic [DATA_W-1:0] c,
                              input logic [DATA_W-1:0] v);
        t_req r;
        r.action      = ACTION_LOAD;
        r.point_index = slot[ADDR_W-1:0];
        r.point_coord = c;
        r.point_value = v;
        r.query_coord = rand_word();
        table_coord[slot] = c;
        send(r);
    endtask

    task automatic query(input logic [DATA_W-1:0] x);
        t_req r;
        r.action      = ACTION_QUERY;
        r.point_index = ADDR_W'($urandom_range(0, MAX_POINTS - 1));
        r.point_coord = rand_word();
        r.point_value = rand_word();
        r.query_coord = x;
        send(r);
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (outstanding != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_count(input int cnt);
        wait_idle();
        i_cfg_we   = 1'b1;
        i_cfg_data = cnt[COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        active_points = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
    endtask

    task automatic fill_table(input int n, input bit ascending);
        longint lo, hi, span, step, c, prev;
        prev = 0;
        case ($urandom_range(0, 3))
            0: begin
                lo = -64'sd2147483648;
                hi = 64'sd2147483647;
            end
            1: begin
                lo = $signed(rand_word());
                hi = lo + $urandom_range(0, 4000);
                if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            end
            default: begin
                lo = $signed(rand_word());
                hi = $signed(rand_word());
                if (hi < lo) begin
                    c  = lo;
                    lo = hi;
                    hi = c;
                end
            end
        endcase
        span = hi - lo;
        step = span / (n - 1);
        for (int i = 0; i < n; i++) begin
            if (ascending) begin
                c = lo + span * i / (n - 1);
                if (step >= 4) c += longint'($urandom) % (step / 4);
                if (i == n - 1) c = hi;
                // repeat a coordinate now and then for a zero-width interval
                if (i > 0 && $urandom_range(0, 9) == 0) c = prev;
                if (i > 0 && c < prev) c = prev;
            end else begin
                c = $signed(rand_word());
            end
            load_point(i, c[DATA_W-1:0], rand_word());
            prev = c;
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_coord();
        longint          lo, hi, x;
        longint unsigned r, span_u;
        int              k, slot;
        if (active_points < 2) return rand_word();
        lo   = table_coord[0];
        hi   = table_coord[active_points-1];
        k    = $urandom_range(0, 99);
        slot = $urandom_range(0, active_points - 1);
        r    = {$urandom, $urandom};
        if (k < 45 && hi >= lo) begin
            span_u = hi - lo + 1;
            x = lo + longint'(r % span_u);
        end else if (k < 65) begin
            x = table_coord[slot];
        end else if (k < 80) begin
            x = table_coord[slot] + (k[0] ? 1 : -1);
        end else begin
            x = $signed(rand_word());
        end
        return x[DATA_W-1:0];
    endfunction

    initial begin
        int sel, cnt, nq;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req         = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        items_sent    = 0;
        active_points = 0;
        no_gaps       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // too few points: empty table, then a single point
        query(rand_word());
        write_count(1);
        query(rand_word());

        // zero-width first interval, value extremes, top coordinate just under max
        load_point(0, 32'hC000_0000, 32'h7FFF_FFFF);
        load_point(1, 32'hC000_0000, 32'h8000_0000);
        load_point(2, 32'hFFFF_0000, 32'h0000_3039);
        load_point(3, 32'h0064_0000, 32'hFFFF_FCF7);
        load_point(4, 32'h7FFF_0000, 32'h7FFF_FFFF);
        load_point(5, 32'h7FFF_FFF0, 32'h8000_0000);
        write_count(6);
        query(32'hC000_0000);
        query(32'hBFFF_FFFF);
        query(32'h8000_0000);
        query(32'h7FFF_FFF0);
        query(32'h7FFF_FFFF);
        query(32'h0000_0000);
        query(32'hFFFF_8000);
        query(32'hFFFF_0000);
        query(32'h0032_0000);
        query(32'h7FFF_8000);
        write_count(2);
        query(32'hC000_0000);
        query(32'hE000_0000);

        // write every slot so any count reads loaded entries only
        fill_table(MAX_POINTS, 1'b1);
        write_count(MAX_POINTS);
        repeat (12) query(pick_coord());

        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 8)       cnt = $urandom_range(0, 1);
            else if (sel < 18) cnt = MAX_POINTS;
            else if (sel < 26) cnt = $urandom_range(MAX_POINTS + 1, COUNT_MAX);
            else if (sel < 60) cnt = $urandom_range(2, 8);
            else               cnt = $urandom_range(2, MAX_POINTS - 1);
            write_count(cnt);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (active_points >= 2) fill_table(active_points, $urandom_range(0, 9) != 0);
            nq = $urandom_range(6, 20);
            repeat (nq) begin
                // stray load: may break the ordering under live queries
                if ($urandom_range(0, 19) == 0)
                    load_point($urandom_range(0, MAX_POINTS - 1), rand_word(), rand_word());
                else
                    query(pick_coord());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/pli_pkg.sv
design/pli_div.sv
design/piecewise_linear_interpolator.sv
tb/interp_result_checker.sv
tb/piecewise_linear_interpolator_test.sv
